// ===== sv/bbrm_pkg.sv =====
package bbrm_pkg;

  // Default number of 64-bit bitmap words.
  localparam int MAP_WORDS_DEF = 64;

  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = 6;
  localparam int BLK_W      = 48;
  localparam int REQ_CNT_W  = 32;
  localparam int SUM_W      = BLK_W + 1;
  localparam int UNIT_W     = 7;
  localparam int CHUNK_W    = 19;
  localparam int MWU_W      = 7;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Offsets that survive the range check are below the chunk size; counts are at most the chunk size.
  localparam int DIVD_W     = CHUNK_W;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int REM_W      = 6;
  localparam int END_W      = DIVD_W + 1;

  localparam int PC_W       = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WORDS  = 3'd3;

  localparam logic [UNIT_W-1:0]  UNIT_RST  = 7'd1;
  localparam logic [CHUNK_W-1:0] CHUNK_RST = 19'd4096;
  localparam logic [MWU_W-1:0]   MWU_RST   = 7'd64;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_OUTSIDE      = 3'd1,
    ST_OFF_MISALIGN = 3'd2,
    ST_CNT_MISALIGN = 3'd3,
    ST_ALREADY_FREE = 3'd4,
    ST_ALREADY_SET  = 3'd5,
    ST_BAD_SIZE     = 3'd6
  } status_e;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SUMS,
    OP_RANGE,
    OP_DIV,
    OP_OFF_DONE,
    OP_CNT_DONE,
    OP_END,
    OP_CHECK,
    OP_REWIND,
    OP_UPDATE,
    OP_REPLY
  } op_e;

  // Conditions the sequencer can test for holding or jumping.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD,
    C_DIV_BUSY,
    C_CLR_MORE,
    C_CHK_CONT,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           hold;
    cond_e           jump;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_input;
    logic bad;
    logic div_busy;
    logic clr_more;
    logic chk_cont;
    logic more;
    logic out_busy;
  } cond_flags_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Step addresses of the control program.
  localparam logic [PC_W-1:0] S_CLEAR    = 4'd0;
  localparam logic [PC_W-1:0] S_IDLE     = 4'd1;
  localparam logic [PC_W-1:0] S_SUMS     = 4'd2;
  localparam logic [PC_W-1:0] S_RANGE    = 4'd3;
  localparam logic [PC_W-1:0] S_DIV_OFF  = 4'd4;
  localparam logic [PC_W-1:0] S_OFF_DONE = 4'd5;
  localparam logic [PC_W-1:0] S_DIV_CNT  = 4'd6;
  localparam logic [PC_W-1:0] S_CNT_DONE = 4'd7;
  localparam logic [PC_W-1:0] S_END      = 4'd8;
  localparam logic [PC_W-1:0] S_CHK_RD   = 4'd9;
  localparam logic [PC_W-1:0] S_CHK      = 4'd10;
  localparam logic [PC_W-1:0] S_CHK_END  = 4'd11;
  localparam logic [PC_W-1:0] S_UPD_RD   = 4'd12;
  localparam logic [PC_W-1:0] S_UPD      = 4'd13;
  localparam logic [PC_W-1:0] S_REPLY    = 4'd14;

  // The control store. Unused addresses return to the idle step.
  function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, hold: C_NONE, jump: C_ALWAYS, target: S_IDLE};
    unique case (pc)
      S_CLEAR:    cw = '{op: OP_CLEAR,    hold: C_CLR_MORE, jump: C_NONE,     target: S_IDLE};
      S_IDLE:     cw = '{op: OP_ACCEPT,   hold: C_NO_INPUT, jump: C_NONE,     target: S_IDLE};
      S_SUMS:     cw = '{op: OP_SUMS,     hold: C_NONE,     jump: C_NONE,     target: S_IDLE};
      S_RANGE:    cw = '{op: OP_RANGE,    hold: C_NONE,     jump: C_BAD,      target: S_REPLY};
      S_DIV_OFF:  cw = '{op: OP_DIV,      hold: C_DIV_BUSY, jump: C_NONE,     target: S_IDLE};
      S_OFF_DONE: cw = '{op: OP_OFF_DONE, hold: C_NONE,     jump: C_BAD,      target: S_REPLY};
      S_DIV_CNT:  cw = '{op: OP_DIV,      hold: C_DIV_BUSY, jump: C_NONE,     target: S_IDLE};
      S_CNT_DONE: cw = '{op: OP_CNT_DONE, hold: C_NONE,     jump: C_BAD,      target: S_REPLY};
      S_END:      cw = '{op: OP_END,      hold: C_NONE,     jump: C_BAD,      target: S_REPLY};
      S_CHK_RD:   cw = '{op: OP_NOP,      hold: C_NONE,     jump: C_NONE,     target: S_IDLE};
      S_CHK:      cw = '{op: OP_CHECK,    hold: C_NONE,     jump: C_CHK_CONT, target: S_CHK_RD};
      S_CHK_END:  cw = '{op: OP_REWIND,   hold: C_NONE,     jump: C_BAD,      target: S_REPLY};
      S_UPD_RD:   cw = '{op: OP_NOP,      hold: C_NONE,     jump: C_NONE,     target: S_IDLE};
      S_UPD:      cw = '{op: OP_UPDATE,   hold: C_NONE,     jump: C_MORE,     target: S_UPD_RD};
      S_REPLY:    cw = '{op: OP_REPLY,    hold: C_OUT_BUSY, jump: C_ALWAYS,   target: S_IDLE};
      default:    cw = '{op: OP_NOP,      hold: C_NONE,     jump: C_ALWAYS,   target: S_IDLE};
    endcase
    return cw;
  endfunction

  // Ones from bit lo up to and including bit hi.
  function automatic logic [WORD_W-1:0] span_mask(logic [BIT_IDX_W-1:0] lo,
                                                  logic [BIT_IDX_W-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (6'd63 - hi));
  endfunction

endpackage

// ===== sv/bbrm_ram.sv =====
module bbrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bbrm_div.sv =====
module bbrm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bbrm_pkg::div_ctrl_t               ctrl_i,
  input  logic [bbrm_pkg::DIVD_W-1:0]       dividend_i,
  input  logic [bbrm_pkg::UNIT_W-1:0]       divisor_i,
  output logic [bbrm_pkg::DIVD_W-1:0]       quo_o,
  output logic [bbrm_pkg::REM_W-1:0]        rem_o,
  output logic                              busy_o
);
  import bbrm_pkg::*;

  // Restoring division, one quotient bit per cycle while step is set.
  logic [DIVD_W-1:0]    quo_q, quo_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W:0]       rem_sh;
  logic [REM_W:0]       rem_sub;

  assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
  assign rem_sub = rem_sh - divisor_i;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = DIV_CNT_W'(DIVD_W);
    end else if (ctrl_i.step && cnt_q != '0) begin
      if (rem_sh >= divisor_i) begin
        rem_d = rem_sub[REM_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[REM_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign busy_o = (cnt_q != '0);

endmodule

// ===== sv/bbrm_seq.sv =====
module bbrm_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bbrm_pkg::cond_flags_t  flags_i,
  output bbrm_pkg::ctrl_word_t   cw_o
);
  import bbrm_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      cw;
  logic            hold_hit;
  logic            jump_hit;

  function automatic logic cond_hit(cond_e c, cond_flags_t f);
    logic hit;
    hit = 1'b0;
    unique case (c)
      C_NONE:     hit = 1'b0;
      C_ALWAYS:   hit = 1'b1;
      C_NO_INPUT: hit = f.no_input;
      C_BAD:      hit = f.bad;
      C_DIV_BUSY: hit = f.div_busy;
      C_CLR_MORE: hit = f.clr_more;
      C_CHK_CONT: hit = f.chk_cont;
      C_MORE:     hit = f.more;
      C_OUT_BUSY: hit = f.out_busy;
      default:    hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign cw       = ucode(pc_q);
  assign hold_hit = cond_hit(cw.hold, flags_i);
  assign jump_hit = cond_hit(cw.jump, flags_i);

  always_comb begin
    if (hold_hit) begin
      pc_d = pc_q;
    end else if (jump_hit) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign cw_o = cw;

endmodule

// ===== sv/bitmap_block_range_mark_core.sv =====
// Allocation bitmap of one storage chunk, one bit per allocation unit.
// Input channel (in_valid_i/in_ready_o): one transaction carries cmd_i (0 marks
// the range allocated, 1 frees it), start_block_i and block_count_i. Output
// channel (out_valid_o/out_ready_i): one transaction per request carries the
// 3-bit status_o. Configuration channel (cfg_valid_i/cfg_ready_o) writes the
// register selected by cfg_index_i with cfg_data_i; it is always ready and
// should only be used while no request is in flight.
// After reset the bitmap RAM is swept to zero, one word per cycle, and the
// input stays not ready until every word is cleared. Configuration registers
// take their reset values at once. A request that passes all checks goes from
// accept to result through two 19-step serial divisions by the unit size, a
// check pass and an update pass over the bitmap words the range touches;
// rejected requests finish earlier. In each pass a touched word takes a read
// step and then a check or update step, as the RAM read is registered and
// read and write share one address. One request is processed at a time, so
// the next is accepted only once the last has left the reply step. The
// result sits in an output register, so the next request is accepted while an
// earlier status waits; a stalled receiver only holds the sequencer once a
// second status is ready to leave.
module bitmap_block_range_mark_core #(
  parameter int MAP_WORDS = bbrm_pkg::MAP_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [bbrm_pkg::BLK_W-1:0]          start_block_i,
  input  logic [bbrm_pkg::REQ_CNT_W-1:0]      block_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bbrm_pkg::STAT_W-1:0]         status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bbrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbrm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bbrm_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  // Width that holds both the words-in-use register and MAP_WORDS itself.
  localparam int WW = ($clog2(MAP_WORDS + 1) > MWU_W) ? $clog2(MAP_WORDS + 1) : MWU_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_WORDS - 1);

  // Configuration registers.
  logic [BLK_W-1:0]   chunk_base_q;
  logic [UNIT_W-1:0]  unit_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [MWU_W-1:0]   mwu_q;

  // Request and working registers.
  logic               cmd_q;
  logic [BLK_W-1:0]   start_q;
  logic [REQ_CNT_W-1:0] count_q;
  logic [SUM_W-1:0]   diff_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   lim_q;
  logic [DIVD_W-1:0]  first_q, first_d;
  logic [END_W-1:0]   end_q, end_d;
  status_e            stat_q, stat_d;
  logic [AW-1:0]      ptr_q, ptr_d;

  logic               out_valid_q;
  status_e            out_status_q;

  ctrl_word_t         cw;
  cond_flags_t        flags;
  div_ctrl_t          div_ctrl;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVD_W-1:0]  quo;
  logic [REM_W-1:0]   rem;
  logic               div_busy;

  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  cur;

  logic               accept;
  logic               push;
  logic               out_busy;
  logic [UNIT_W-1:0]  unit_eff;
  logic [WW-1:0]      mwu_ext;
  logic [WW-1:0]      words;
  logic [WW+5:0]      unit_limit;
  logic               too_long;
  logic [END_W-1:0]   end_m1;
  logic [AW-1:0]      first_word;
  logic [AW-1:0]      last_word;
  logic [BIT_IDX_W-1:0] lo_bit;
  logic [BIT_IDX_W-1:0] hi_bit;
  logic [WORD_W-1:0]  mask;
  logic               fail;

  bbrm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cw_o    (cw)
  );

  bbrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (unit_eff),
    .quo_o      (quo),
    .rem_o      (rem),
    .busy_o     (div_busy)
  );

  bbrm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cur)
  );

  // A unit size of zero behaves as one block per bit.
  assign unit_eff = (unit_q == '0) ? UNIT_W'(1) : unit_q;

  // The usable bitmap is the smaller of the configured word count and the RAM.
  assign mwu_ext    = WW'(mwu_q);
  assign words      = (mwu_ext < WW'(MAP_WORDS)) ? mwu_ext : WW'(MAP_WORDS);
  assign unit_limit = {words, 6'b0};
  assign too_long   = 32'(end_q) > 32'(unit_limit);

  // Word range of the request and the bit span inside the current word.
  assign end_m1     = end_q - END_W'(1);
  assign first_word = first_q[AW+5:6];
  assign last_word  = end_m1[AW+5:6];
  assign lo_bit     = (ptr_q == first_word) ? first_q[5:0] : '0;
  assign hi_bit     = (ptr_q == last_word) ? end_m1[5:0] : '1;
  assign mask       = span_mask(lo_bit, hi_bit);

  // Freeing needs every bit of the span set; marking needs every bit clear.
  assign fail = cmd_q ? ((cur & mask) != mask) : ((cur & mask) != '0);

  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    stat_d       = stat_q;
    ptr_d        = ptr_q;
    first_d      = first_q;
    end_d        = end_q;
    div_ctrl     = '0;
    div_dividend = diff_q[DIVD_W-1:0];
    ram_we       = 1'b0;
    ram_wdata    = '0;
    push         = 1'b0;
    accept       = 1'b0;
    unique case (cw.op)
      OP_NOP: begin
      end
      OP_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_q != CLR_LAST) begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      OP_ACCEPT: begin
        accept = in_valid_i;
        stat_d = ST_OK;
      end
      OP_SUMS: begin
      end
      OP_RANGE: begin
        div_ctrl.load = 1'b1;
        if (count_q == '0) begin
          stat_d = ST_BAD_SIZE;
        end else if (diff_q[SUM_W-1] || (sum_q > lim_q)) begin
          stat_d = ST_OUTSIDE;
        end
      end
      OP_DIV: begin
        div_ctrl.step = 1'b1;
      end
      OP_OFF_DONE: begin
        if (rem != '0) begin
          stat_d = ST_OFF_MISALIGN;
        end
        first_d       = quo;
        div_ctrl.load = 1'b1;
        div_dividend  = count_q[DIVD_W-1:0];
      end
      OP_CNT_DONE: begin
        if (rem != '0) begin
          stat_d = ST_CNT_MISALIGN;
        end
        end_d = END_W'(first_q) + END_W'(quo);
      end
      OP_END: begin
        if (too_long) begin
          stat_d = ST_BAD_SIZE;
        end
        ptr_d = first_word;
      end
      OP_CHECK: begin
        if (fail) begin
          stat_d = cmd_q ? ST_ALREADY_FREE : ST_ALREADY_SET;
        end else if (ptr_q != last_word) begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      OP_REWIND: begin
        ptr_d = first_word;
      end
      OP_UPDATE: begin
        ram_we    = 1'b1;
        ram_wdata = cmd_q ? (cur & ~mask) : (cur | mask);
        if (ptr_q != last_word) begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      OP_REPLY: begin
        push = !out_busy;
      end
      default: begin
      end
    endcase
  end

  // Conditions for the sequencer. The status flag looks at the value written
  // this cycle, so a failing range, alignment or size step jumps to the reply.
  always_comb begin
    flags.no_input = !in_valid_i;
    flags.bad      = (stat_d != ST_OK);
    flags.div_busy = div_busy;
    flags.clr_more = (ptr_q != CLR_LAST);
    flags.chk_cont = !fail && (ptr_q != last_word);
    flags.more     = (ptr_q != last_word);
    flags.out_busy = out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_base_q <= '0;
      unit_q       <= UNIT_RST;
      chunk_q      <= CHUNK_RST;
      mwu_q        <= MWU_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHUNK_BASE: chunk_base_q <= cfg_data_i[BLK_W-1:0];
        REG_UNIT:       unit_q       <= cfg_data_i[UNIT_W-1:0];
        REG_CHUNK:      chunk_q      <= cfg_data_i[CHUNK_W-1:0];
        REG_MAP_WORDS:  mwu_q        <= cfg_data_i[MWU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      stat_q <= stat_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      start_q <= start_block_i;
      count_q <= block_count_i;
    end
    if (cw.op == OP_SUMS) begin
      diff_q <= {1'b0, start_q} - {1'b0, chunk_base_q};
      sum_q  <= SUM_W'(start_q) + SUM_W'(count_q);
      lim_q  <= SUM_W'(chunk_base_q) + SUM_W'(chunk_q);
    end
    first_q <= first_d;
    end_q   <= end_d;
    if (push) begin
      out_status_q <= stat_q;
    end
  end

  assign in_ready_o  = (cw.op == OP_ACCEPT);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  // The bitmap is only written by the clearing sweep or by a request that
  // passed every check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((cw.op == OP_CLEAR) || (stat_q == ST_OK)))
    else $error("bitmap written by a failing request");

  // An accepted request always starts with the address sums.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cw.op == OP_SUMS))
    else $error("request accepted but sequencer did not start");

  // A new status appears only from the reply step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cw.op == OP_REPLY))
    else $error("status raised outside the reply step");

  // The word pointer never runs past the last word of the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cw.op == OP_CHECK) || (cw.op == OP_UPDATE)) |-> (ptr_q <= last_word))
    else $error("word pointer past the end of the range");

endmodule
